/* rtl/bpc_pkg.sv */
// Shared types, microcode fields and arithmetic constants for the barometer compensation block.
package bpc_pkg;

  // Datapath widths
  localparam int DT_W   = 26;  // kept temperature difference
  localparam int MA_W   = 26;  // multiplier operand a
  localparam int MB_W   = 19;  // multiplier operand b
  localparam int PROD_W = 45;  // multiplier product
  localparam int OFF_W  = 36;  // offset and sensitivity
  localparam int ACC_W  = 62;  // wide accumulator
  localparam int COEF_W = 16;
  localparam int RES_W  = 32;
  localparam int PC_W   = 4;

  // Scaling shifts (low-range variant, high-range variant)
  localparam int TEMP_SH     = 23;
  localparam int TEMP_BASE   = 2000;
  localparam int REF_SH      = 8;
  localparam int OFF_C_SH_LO = 17;
  localparam int OFF_C_SH_HI = 16;
  localparam int OFF_D_SH_LO = 6;
  localparam int OFF_D_SH_HI = 7;
  localparam int SNS_C_SH_LO = 16;
  localparam int SNS_C_SH_HI = 15;
  localparam int SNS_D_SH_LO = 7;
  localparam int SNS_D_SH_HI = 8;
  localparam int PMUL_SH     = 21;
  localparam int PRES_SH     = 15;
  localparam int SPLIT_W     = 18;  // low part of the sensitivity for the split multiply

  // Configuration register indexes
  localparam logic [2:0] REG_SENS     = 3'd0;
  localparam logic [2:0] REG_OFFSET   = 3'd1;
  localparam logic [2:0] REG_SENS_TC  = 3'd2;
  localparam logic [2:0] REG_OFF_TC   = 3'd3;
  localparam logic [2:0] REG_REF_TEMP = 3'd4;
  localparam logic [2:0] REG_TEMP_GN  = 3'd5;
  localparam logic [2:0] REG_VARIANT  = 3'd6;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DT_C6,
    MUL_DT_C4,
    MUL_DT_C3,
    MUL_RAW_SLO,
    MUL_RAW_SHI
  } mul_sel_e;

  // Arithmetic unit operations
  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_DT,
    ALU_TEMP,
    ALU_OFF,
    ALU_SENS,
    ALU_ACC_LO,
    ALU_ACC_HI,
    ALU_PDIV,
    ALU_PRES
  } alu_op_e;

  // One control word of the program
  typedef struct packed {
    mul_sel_e         mul_sel;
    alu_op_e          alu_op;
    logic             jump_press;  // jump to target on a pressure request
    logic [PC_W-1:0]  target;
    logic             last;
  } ucode_t;

  // Divide by 2^sh, truncating toward zero
  function automatic logic signed [ACC_W-1:0] tdiv_pow2(input logic signed [ACC_W-1:0] x,
                                                       input int unsigned sh);
    logic signed [ACC_W-1:0] q;
    logic [ACC_W-1:0]        mask;
    logic                    rnd;
    mask = (ACC_W'(1) << sh) - ACC_W'(1);
    q    = x >>> sh;
    rnd  = x[ACC_W-1] && ((x & mask) != '0);
    return q + ACC_W'(rnd);
  endfunction

endpackage

/* rtl/bpc_seq.sv */
// Microcode sequencer: program table, step counter and conditional jumps.
module bpc_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            press_i,
  input  logic            stall_i,
  output bpc_pkg::ucode_t ctrl_o,
  output logic            en_o,
  output logic            busy_o
);
  import bpc_pkg::*;

  localparam logic [PC_W-1:0] STEP_PRESS = PC_W'(4);
  localparam int              PROG_LEN   = 12;

  // Program table: temperature steps 1-3, pressure steps 4-11
  function automatic ucode_t rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{mul_sel: MUL_NONE, alu_op: ALU_NOP, jump_press: 1'b0, target: '0, last: 1'b1};
    unique case (pc)
      PC_W'(0):  w = '{MUL_NONE,    ALU_NOP,    1'b1, STEP_PRESS, 1'b0};
      PC_W'(1):  w = '{MUL_NONE,    ALU_DT,     1'b0, '0,         1'b0};
      PC_W'(2):  w = '{MUL_DT_C6,   ALU_NOP,    1'b0, '0,         1'b0};
      PC_W'(3):  w = '{MUL_NONE,    ALU_TEMP,   1'b0, '0,         1'b1};
      PC_W'(4):  w = '{MUL_DT_C4,   ALU_NOP,    1'b0, '0,         1'b0};
      PC_W'(5):  w = '{MUL_DT_C3,   ALU_OFF,    1'b0, '0,         1'b0};
      PC_W'(6):  w = '{MUL_NONE,    ALU_SENS,   1'b0, '0,         1'b0};
      PC_W'(7):  w = '{MUL_RAW_SLO, ALU_NOP,    1'b0, '0,         1'b0};
      PC_W'(8):  w = '{MUL_RAW_SHI, ALU_ACC_LO, 1'b0, '0,         1'b0};
      PC_W'(9):  w = '{MUL_NONE,    ALU_ACC_HI, 1'b0, '0,         1'b0};
      PC_W'(10): w = '{MUL_NONE,    ALU_PDIV,   1'b0, '0,         1'b0};
      PC_W'(11): w = '{MUL_NONE,    ALU_PRES,   1'b0, '0,         1'b1};
      default:   ;
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_q, pc_d;
  logic            busy_q, busy_d;
  ucode_t          ctrl;
  logic            adv;

  assign ctrl   = rom(pc_q);
  assign adv    = busy_q && !stall_i;
  assign ctrl_o = ctrl;
  assign en_o   = adv;
  assign busy_o = busy_q;

  // Advance, jump or finish
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (start_i) begin
      pc_d   = '0;
      busy_d = 1'b1;
    end else if (adv) begin
      if (ctrl.last) begin
        pc_d   = '0;
        busy_d = 1'b0;
      end else if (ctrl.jump_press && press_i) begin
        pc_d = ctrl.target;
      end else begin
        pc_d = pc_q + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  a_pc_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q < PC_W'(PROG_LEN)))
    else $error("step counter left the program");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ctrl.last && !start_i) |=> !busy_q)
    else $error("sequencer still busy after final step");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("request started while a program runs");

endmodule

/* rtl/baro_pressure_temp_compensation_top.sv */
// Top level of the barometer compensation block: channels, calibration registers, datapath.
//
// Usage:
//   Requests enter on req_valid_i/req_ready_o with command_i (0 temperature,
//   1 pressure) and raw_sample_i. Each request gives one response on
//   rsp_valid_o/rsp_ready_i: result_kind_o equals the command and
//   result_value_o is centidegrees or pascals. A temperature request keeps
//   its difference from the reference temperature for later pressure requests.
//   The user writes calibration words through cfg_we_i/cfg_idx_i/cfg_wdata_i while the
//   block is idle; the block does not enforce this. An index above six is ignored.
// Timing:
//   A microcoded program drives one shared 26x19 multiplier. A temperature
//   response is registered at the final step of its program, and a pressure
//   response likewise, the wide product raw x sensitivity taking two multiplier
//   passes. A new request is taken in the cycle after the last program step, so
//   one request runs at a time and a new one waits while the program is busy.
//   The response register lets the next request run while a response waits;
//   if the receiver still stalls, the program holds on its final step.
// Reset clears the calibration words, the kept difference, the response valid and the busy flag.
module baro_pressure_temp_compensation_top #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  input  logic                   command_i,
  input  logic [SAMPLE_BITS-1:0] raw_sample_i,
  output logic                   rsp_valid_o,
  input  logic                   rsp_ready_i,
  output logic                   result_kind_o,
  output logic signed [31:0]     result_value_o,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [15:0]            cfg_wdata_i
);
  import bpc_pkg::*;

  // Calibration registers
  logic [COEF_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic              variant_q;

  // Request and working registers
  logic                          cmd_q;
  logic [SAMPLE_BITS-1:0]        raw_q;
  logic signed [DT_W-1:0]        dt_q;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic signed [OFF_W-1:0]       off_q, sens_q;
  logic signed [ACC_W-1:0]       acc_q;

  // Response register
  logic                     rsp_valid_q;
  logic                     rsp_kind_q;
  logic signed [RES_W-1:0]  rsp_value_q;

  ucode_t ctrl;
  logic   en, busy, start, stall, load;

  assign req_ready_o = !busy;
  assign start       = req_valid_i && req_ready_o;
  assign stall       = ctrl.last && rsp_valid_q && !rsp_ready_i;
  assign load        = en && ctrl.last;

  bpc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .press_i (cmd_q),
    .stall_i (stall),
    .ctrl_o  (ctrl),
    .en_o    (en),
    .busy_o  (busy)
  );

  // Write calibration words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q      <= '0;
      c2_q      <= '0;
      c3_q      <= '0;
      c4_q      <= '0;
      c5_q      <= '0;
      c6_q      <= '0;
      variant_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SENS:     c1_q      <= cfg_wdata_i;
        REG_OFFSET:   c2_q      <= cfg_wdata_i;
        REG_SENS_TC:  c3_q      <= cfg_wdata_i;
        REG_OFF_TC:   c4_q      <= cfg_wdata_i;
        REG_REF_TEMP: c5_q      <= cfg_wdata_i;
        REG_TEMP_GN:  c6_q      <= cfg_wdata_i;
        REG_VARIANT:  variant_q <= cfg_wdata_i[0];
        default:      ;
      endcase
    end
  end

  // Shared multiplier operands
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;

  always_comb begin
    mul_a = dt_q;
    mul_b = '0;
    unique case (ctrl.mul_sel)
      MUL_DT_C6:   mul_b = $signed(MB_W'(c6_q));
      MUL_DT_C4:   mul_b = $signed(MB_W'(c4_q));
      MUL_DT_C3:   mul_b = $signed(MB_W'(c3_q));
      MUL_RAW_SLO: begin
        mul_a = $signed(MA_W'(raw_q));
        mul_b = $signed(MB_W'(sens_q[SPLIT_W-1:0]));
      end
      MUL_RAW_SHI: begin
        mul_a = $signed(MA_W'(raw_q));
        mul_b = MB_W'($signed(sens_q[OFF_W-1:SPLIT_W]));
      end
      default:     ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Arithmetic unit results
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [DT_W-1:0]   dt_new;
  logic signed [OFF_W-1:0]  off_base, sens_base;
  logic signed [ACC_W-1:0]  off_frac, sens_frac;
  logic signed [OFF_W-1:0]  off_new, sens_new;
  logic signed [RES_W-1:0]  temp_val, pres_val;

  assign prod_ext = ACC_W'(prod_q);
  assign dt_new   = $signed(DT_W'(raw_q)) - $signed(DT_W'({c5_q, REF_SH'(0)}));

  // Offset and sensitivity terms follow the selected variant
  assign off_base  = variant_q ? $signed(OFF_W'(c2_q) << OFF_C_SH_HI)
                               : $signed(OFF_W'(c2_q) << OFF_C_SH_LO);
  assign off_frac  = variant_q ? tdiv_pow2(prod_ext, OFF_D_SH_HI)
                               : tdiv_pow2(prod_ext, OFF_D_SH_LO);
  assign sens_base = variant_q ? $signed(OFF_W'(c1_q) << SNS_C_SH_HI)
                               : $signed(OFF_W'(c1_q) << SNS_C_SH_LO);
  assign sens_frac = variant_q ? tdiv_pow2(prod_ext, SNS_D_SH_HI)
                               : tdiv_pow2(prod_ext, SNS_D_SH_LO);
  assign off_new   = off_base + OFF_W'(off_frac);
  assign sens_new  = sens_base + OFF_W'(sens_frac);

  assign temp_val = RES_W'(tdiv_pow2(prod_ext, TEMP_SH) + ACC_W'(TEMP_BASE));
  assign pres_val = RES_W'(tdiv_pow2(acc_q, PRES_SH));

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q <= command_i;
      raw_q <= raw_sample_i;
    end
  end

  // Keep the temperature difference across requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= '0;
    end else if (en && ctrl.alu_op == ALU_DT) begin
      dt_q <= dt_new;
    end
  end

  // Step the datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ctrl.mul_sel != MUL_NONE) begin
        prod_q <= prod_d;
      end
      unique case (ctrl.alu_op)
        ALU_OFF:    off_q  <= off_new;
        ALU_SENS:   sens_q <= sens_new;
        ALU_ACC_LO: acc_q  <= prod_ext;
        ALU_ACC_HI: acc_q  <= acc_q + (prod_ext <<< SPLIT_W);
        ALU_PDIV:   acc_q  <= tdiv_pow2(acc_q, PMUL_SH) - ACC_W'(off_q);
        default:    ;
      endcase
    end
  end

  // Hold the response until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp_kind_q  <= cmd_q;
      rsp_value_q <= (ctrl.alu_op == ALU_PRES) ? pres_val : temp_val;
    end
  end

  assign rsp_valid_o    = rsp_valid_q;
  assign result_kind_o  = rsp_kind_q;
  assign result_value_o = rsp_value_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !(rsp_valid_q && !rsp_ready_i))
    else $error("response overwritten before it was taken");

  a_final_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> ((cmd_q && ctrl.alu_op == ALU_PRES) || (!cmd_q && ctrl.alu_op == ALU_TEMP)))
    else $error("program ended on the wrong branch");

  a_temp_keeps_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && ctrl.alu_op == ALU_DT) |-> !cmd_q)
    else $error("pressure request altered the kept difference");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> rsp_valid_o)
    else $error("finished response not presented");

endmodule
